>>> hdl/tac_pkg.sv
package tac_pkg;

  localparam int TBL_POINTS = 33;
  localparam int TBL_IDX_W  = 6;
  localparam int CODE_W     = 12;
  localparam int TEMP_W     = 16;
  localparam int OUT_W      = 15;
  localparam int MAG_W      = 15;
  localparam int OFF_W      = 13;
  localparam int PROD_W     = MAG_W + OFF_W;

  localparam logic signed [TEMP_W-1:0] RESET_TEMP = 16'sd2500;

  function automatic logic [CODE_W-1:0] code_at(input logic [TBL_IDX_W-1:0] i);
    logic [CODE_W-1:0] c;
    case (i)
      6'd0:    c = 12'd1;
      6'd1:    c = 12'd128;
      6'd2:    c = 12'd256;
      6'd3:    c = 12'd384;
      6'd4:    c = 12'd512;
      6'd5:    c = 12'd640;
      6'd6:    c = 12'd768;
      6'd7:    c = 12'd896;
      6'd8:    c = 12'd1024;
      6'd9:    c = 12'd1152;
      6'd10:   c = 12'd1280;
      6'd11:   c = 12'd1408;
      6'd12:   c = 12'd1536;
      6'd13:   c = 12'd1664;
      6'd14:   c = 12'd1792;
      6'd15:   c = 12'd1920;
      6'd16:   c = 12'd2048;
      6'd17:   c = 12'd2176;
      6'd18:   c = 12'd2304;
      6'd19:   c = 12'd2432;
      6'd20:   c = 12'd2560;
      6'd21:   c = 12'd2688;
      6'd22:   c = 12'd2816;
      6'd23:   c = 12'd2944;
      6'd24:   c = 12'd3072;
      6'd25:   c = 12'd3200;
      6'd26:   c = 12'd3328;
      6'd27:   c = 12'd3456;
      6'd28:   c = 12'd3584;
      6'd29:   c = 12'd3712;
      6'd30:   c = 12'd3840;
      6'd31:   c = 12'd3968;
      default: c = 12'd4094;
    endcase
    return c;
  endfunction

  function automatic logic signed [TEMP_W-1:0] centi_at(input logic [TBL_IDX_W-1:0] i);
    logic signed [TEMP_W-1:0] t;
    case (i)
      6'd0:    t = 16'sd12500;
      6'd1:    t = 16'sd12500;
      6'd2:    t = 16'sd10159;
      6'd3:    t = 16'sd8660;
      6'd4:    t = 16'sd7632;
      6'd5:    t = 16'sd6848;
      6'd6:    t = 16'sd6210;
      6'd7:    t = 16'sd5668;
      6'd8:    t = 16'sd5195;
      6'd9:    t = 16'sd4772;
      6'd10:   t = 16'sd4386;
      6'd11:   t = 16'sd4029;
      6'd12:   t = 16'sd3695;
      6'd13:   t = 16'sd3378;
      6'd14:   t = 16'sd3075;
      6'd15:   t = 16'sd2783;
      6'd16:   t = 16'sd2499;
      6'd17:   t = 16'sd2220;
      6'd18:   t = 16'sd1944;
      6'd19:   t = 16'sd1668;
      6'd20:   t = 16'sd1392;
      6'd21:   t = 16'sd1111;
      6'd22:   t = 16'sd824;
      6'd23:   t = 16'sd526;
      6'd24:   t = 16'sd215;
      6'd25:   t = -16'sd116;
      6'd26:   t = -16'sd473;
      6'd27:   t = -16'sd869;
      6'd28:   t = -16'sd1322;
      6'd29:   t = -16'sd1863;
      6'd30:   t = -16'sd2566;
      6'd31:   t = -16'sd3648;
      default: t = -16'sd4000;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/tac_front.sv
module tac_front #(
  parameter int ADC_BITS = 12,
  parameter int DATA_W   = 16
) (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [DATA_W-1:0]   s_tdata,
  input  logic [0:0]          s_tuser,
  input  logic                q_full,
  output logic                q_push,
  output logic [ADC_BITS:0]   q_wdata
);

  localparam logic [ADC_BITS-1:0] ONE = {{(ADC_BITS-1){1'b0}}, 1'b1};

  logic [ADC_BITS-1:0] raw;
  logic [ADC_BITS-1:0] clamped;

  assign raw = s_tdata[ADC_BITS-1:0];

  always_comb begin
    if (raw == '0) begin
      clamped = ONE;
    end else if (raw == '1) begin
      clamped = raw - ONE;
    end else begin
      clamped = raw;
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign q_wdata  = {s_tuser[0], clamped};

endmodule

>>> hdl/tac_queue.sv
module tac_queue #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         valid
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign rdata = mem[rd_ptr];
  assign valid = count != 2'd0;
  assign full  = count == 2'd2;

endmodule

>>> hdl/tac_div.sv
module tac_div #(
  parameter int N = 28,
  parameter int D = 13
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CNT_W = $clog2(N);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [N-1:0]     dvd;
  logic [D-1:0]     rem;
  logic [D:0]       rem_sh;
  logic             fits;

  assign rem_sh = {rem, dvd[N-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[N-2:0], 1'b0};
      if (fits) begin
        rem      <= D'(rem_sh - {1'b0, divisor});
        quotient <= {quotient[N-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[D-1:0];
        quotient <= {quotient[N-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hdl/tac_back.sv
module tac_back #(
  parameter int ADC_BITS     = 12,
  parameter int TABLE_POINTS = 33
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  logic [ADC_BITS:0]                    q_rdata,
  output logic                                 q_pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tac_pkg::OUT_W-1:0]            out_temp_centi,
  output logic                                 out_held
);

  localparam int NPTS  = (TABLE_POINTS > tac_pkg::TBL_POINTS) ?
                         tac_pkg::TBL_POINTS : TABLE_POINTS;
  localparam int CMP_W = (ADC_BITS > tac_pkg::CODE_W) ? ADC_BITS : tac_pkg::CODE_W;
  localparam logic [tac_pkg::TBL_IDX_W-1:0] LAST_IDX = tac_pkg::TBL_IDX_W'(NPTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t                               state;
  logic [ADC_BITS-1:0]                  sample;
  logic [tac_pkg::TBL_IDX_W-1:0]        idx;
  logic [tac_pkg::CODE_W-1:0]           cprev;
  logic signed [tac_pkg::TEMP_W-1:0]    tprev;
  logic signed [tac_pkg::TEMP_W-1:0]    t0;
  logic                                 dneg;
  logic [tac_pkg::MAG_W-1:0]            mag;
  logic [tac_pkg::OFF_W-1:0]            off;
  logic [tac_pkg::OFF_W-1:0]            span;
  logic [tac_pkg::PROD_W-1:0]           prod;
  logic                                 div_go;
  logic                                 div_done;
  logic [tac_pkg::PROD_W-1:0]           div_quo;
  logic signed [tac_pkg::TEMP_W-1:0]    last_temp;
  logic signed [tac_pkg::TEMP_W-1:0]    out_temp;

  logic [tac_pkg::CODE_W-1:0]           code_cur;
  logic signed [tac_pkg::TEMP_W-1:0]    centi_cur;
  logic [CMP_W-1:0]                     sample_ext;
  logic signed [tac_pkg::TEMP_W:0]      dt;
  logic [tac_pkg::TEMP_W:0]             dt_abs;
  logic signed [tac_pkg::TEMP_W-1:0]    q_signed;
  logic signed [tac_pkg::TEMP_W-1:0]    interp;

  assign code_cur   = tac_pkg::code_at(idx);
  assign centi_cur  = tac_pkg::centi_at(idx);
  assign sample_ext = CMP_W'(sample);
  assign dt         = {centi_cur[tac_pkg::TEMP_W-1], centi_cur}
                    - {tprev[tac_pkg::TEMP_W-1], tprev};
  assign dt_abs     = dt[tac_pkg::TEMP_W] ? (~dt + 1'b1) : dt;
  assign q_signed   = {1'b0, div_quo[tac_pkg::MAG_W-1:0]};
  assign interp     = dneg ? (t0 - q_signed) : (t0 + q_signed);

  tac_div #(
    .N(tac_pkg::PROD_W),
    .D(tac_pkg::OFF_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (prod),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_temp <= tac_pkg::RESET_TEMP;
      div_go    <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (!q_rdata[ADC_BITS]) begin
              out_temp <= last_temp;
              out_held <= 1'b1;
              state    <= ST_OUT;
            end else begin
              sample <= q_rdata[ADC_BITS-1:0];
              idx    <= '0;
              state  <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (sample_ext <= CMP_W'(code_cur)) begin
            if (idx == '0 || code_cur <= cprev) begin
              last_temp <= centi_cur;
              out_temp  <= centi_cur;
              out_held  <= 1'b0;
              state     <= ST_OUT;
            end else begin
              t0    <= tprev;
              dneg  <= dt[tac_pkg::TEMP_W];
              mag   <= dt_abs[tac_pkg::MAG_W-1:0];
              off   <= tac_pkg::OFF_W'(sample_ext - CMP_W'(cprev));
              span  <= tac_pkg::OFF_W'({1'b0, code_cur} - {1'b0, cprev});
              state <= ST_MUL;
            end
          end else if (idx == LAST_IDX) begin
            last_temp <= centi_cur;
            out_temp  <= centi_cur;
            out_held  <= 1'b0;
            state     <= ST_OUT;
          end else begin
            cprev <= code_cur;
            tprev <= centi_cur;
            idx   <= idx + 1'b1;
          end
        end
        ST_MUL: begin
          prod   <= tac_pkg::PROD_W'(mag) * tac_pkg::PROD_W'(off);
          div_go <= 1'b1;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            last_temp <= interp;
            out_temp  <= interp;
            out_held  <= 1'b0;
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign q_pop          = (state == ST_IDLE) && q_valid;
  assign m_tvalid       = state == ST_OUT;
  assign out_temp_centi = out_temp[tac_pkg::OUT_W-1:0];

endmodule

>>> hdl/thermistor_adc_to_centidegree_top.sv
// A failed conversion goes from the queue straight to the output; a converted sample passes
// a segment scan and, when it falls between table points, a multiply and a 28-step divider.
// The back end handles one request at a time; a two-entry queue keeps accepting until full.
// Throughput is one request per back-end pass, set by the scan, the divider and m_tready.
// Reset is synchronous: the queue empties, the output goes invalid, last value becomes 2500.
module thermistor_adc_to_centidegree_top #(
  parameter int TABLE_POINTS = 33,
  parameter int ADC_BITS     = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Bits from the lowest up: adc_sample, then zero fill.
  input  logic [((ADC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // Bit 0: conversion_ok.
  input  logic [0:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Bits from the lowest up: temp_centi (15 bits), then zero fill.
  output logic [15:0]                      m_tdata,
  // Bit 0: held.
  output logic [0:0]                       m_tuser
);

  localparam int S_DATA_W = ((ADC_BITS + 7) / 8) * 8;

  logic                          q_push;
  logic                          q_full;
  logic                          q_pop;
  logic                          q_valid;
  logic [ADC_BITS:0]             q_wdata;
  logic [ADC_BITS:0]             q_rdata;
  logic [tac_pkg::OUT_W-1:0]     temp_centi;
  logic                          held;

  tac_front #(
    .ADC_BITS(ADC_BITS),
    .DATA_W  (S_DATA_W)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  tac_queue #(
    .W(ADC_BITS + 1)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  tac_back #(
    .ADC_BITS    (ADC_BITS),
    .TABLE_POINTS(TABLE_POINTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .out_temp_centi (temp_centi),
    .out_held       (held)
  );

  assign m_tdata = {1'b0, temp_centi};
  assign m_tuser = held;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue read while empty");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule
